[rtl/bfm_pkg.sv]
// Shared constants and types for the bloom filter membership block.
package bfm_pkg;

  localparam int DEF_MAX_FILTER_BITS = 65536;
  localparam int BITS_PER_BYTE       = 8;
  localparam int CFG_W               = 17;
  localparam int HASH_W              = 32;
  localparam int LOAD_ADDR_W         = 13;
  localparam logic [CFG_W-1:0] FILTER_BITS_RESET = 17'd65536;

  typedef enum logic [1:0] {
    ACT_CHECK = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_LOAD  = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef struct packed {
    logic             start;
    logic [HASH_W-1:0] dividend;
    logic [CFG_W-1:0] divisor;
  } mod_req_t;

endpackage

[rtl/bfm_mod.sv]
// Restoring remainder unit: one quotient bit per cycle, 32 steps per word.
module bfm_mod import bfm_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  mod_req_t         req,
  output logic             done,
  output logic [CFG_W-1:0] remainder
);

  localparam int CntW = $clog2(HASH_W + 1);

  logic              busy_r, busy_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [HASH_W-1:0] quo_r, quo_nxt;
  logic [CFG_W-1:0]  rem_r, rem_nxt;
  logic [CFG_W-1:0]  div_r, div_nxt;
  logic [CFG_W:0]    trial;
  logic [CFG_W:0]    diff;

  assign trial = {rem_r, quo_r[HASH_W-1]};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(HASH_W);
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      div_nxt  = req.divisor;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        cnt_nxt = cnt_r - 1'b1;
        quo_nxt = {quo_r[HASH_W-2:0], 1'b0};
        // subtract when the shifted partial remainder reaches the divisor
        if (trial >= {1'b0, div_r}) begin
          rem_nxt = diff[CFG_W-1:0];
        end else begin
          rem_nxt = trial[CFG_W-1:0];
        end
      end else begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = busy_r && (cnt_r == '0);
  assign remainder = rem_r;

endmodule

[rtl/bloom_filter_membership.sv]
// Bloom filter bit store: tests and sets hash positions of keys, restores saved bytes.
// Each check or add word goes through the remainder unit, which reduces the hash word
// modulo the filter size, then a read of the store byte, then a step that tests it and,
// for an add, writes it back; a key's last word waits in that step while a finished
// result still waits at the output. in_ready is high only in idle, so no new word is
// taken before the last one is through. A load beat is written to the store as it is
// accepted, and an undefined action is dropped. The result of a key's last word sits
// in an output register while the next word is taken. After reset the store is cleared
// one byte a cycle, all (MAX_FILTER_BITS+7)/8 bytes (8192 at the default size), during
// which no input beat is accepted; configuration writes are taken at any time. A
// filter_bits of 0 acts as 1 and a value above MAX_FILTER_BITS acts as MAX_FILTER_BITS.
module bloom_filter_membership import bfm_pkg::*; #(
  parameter int MAX_FILTER_BITS = DEF_MAX_FILTER_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_action,
  input  logic [HASH_W-1:0]      in_hash_word,
  input  logic                   in_last_word,
  input  logic [LOAD_ADDR_W-1:0] in_load_address,
  input  logic [7:0]             in_load_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_all_present,
  output logic                   out_was_add
);

  localparam int StoreBytes = (MAX_FILTER_BITS + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int ByteSelW   = $clog2(BITS_PER_BYTE);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_RMW   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CFG_W-1:0] filter_bits_r;
  logic [AddrW-1:0] clr_addr_r, clr_addr_nxt;
  act_t             act_r;
  logic             last_r;
  logic             hits_r, hits_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_all_r, out_all_nxt;
  logic             out_add_r, out_add_nxt;
  logic [ByteSelW-1:0] bit_sel_r;
  logic [AddrW-1:0] rmw_addr_r;

  logic [7:0]       mem [StoreBytes];
  logic [7:0]       rd_data_r;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [7:0]       wr_data;

  logic             accept;
  act_t             in_act;
  logic [CFG_W-1:0] eff_size;
  mod_req_t         mod_req;
  logic             mod_done;
  logic [CFG_W-1:0] mod_rem;
  logic [CFG_W-ByteSelW-1:0] pos_idx;
  logic [AddrW-1:0] look_addr;
  logic             hit;
  logic             hits_now;
  logic             rmw_go;
  logic             load_ok;
  logic [31:0]      load_addr_ext;
  logic [31:0]      pos_idx_ext;

  assign in_act   = act_t'(in_action);
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    eff_size = filter_bits_r;
    if (eff_size == '0) begin
      eff_size = CFG_W'(1);
    end
    if (32'(filter_bits_r) > MAX_FILTER_BITS) begin
      eff_size = CFG_W'(MAX_FILTER_BITS);
    end
  end

  assign mod_req.start    = accept && (in_act == ACT_CHECK || in_act == ACT_ADD);
  assign mod_req.dividend = in_hash_word;
  assign mod_req.divisor  = eff_size;

  bfm_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (mod_req),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign pos_idx     = mod_rem[CFG_W-1:ByteSelW];
  assign pos_idx_ext = 32'(pos_idx);
  // positions past the store fold onto byte zero
  assign look_addr   = (pos_idx_ext >= StoreBytes) ? '0 : pos_idx_ext[AddrW-1:0];

  assign load_addr_ext = 32'(in_load_address);
  assign load_ok       = load_addr_ext < StoreBytes;

  assign hit      = rd_data_r[bit_sel_r];
  assign hits_now = hits_r && hit;
  assign rmw_go   = (state_r == ST_RMW) && (!last_r || !out_valid_r || out_ready);

  assign rd_en   = (state_r == ST_DIV) && mod_done;
  assign rd_addr = look_addr;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rmw_addr_r;
    wr_data = rd_data_r | (8'd1 << bit_sel_r);
    if (state_r == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_r;
      wr_data = '0;
    end else if (accept && in_act == ACT_LOAD) begin
      wr_en   = load_ok;
      wr_addr = load_addr_ext[AddrW-1:0];
      wr_data = in_load_byte;
    end else if (rmw_go && act_r == ACT_ADD && !hit) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    hits_nxt      = hits_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_all_nxt   = out_all_r;
    out_add_nxt   = out_add_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AddrW'(StoreBytes - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (mod_req.start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (mod_done) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        // hold a key's last word here while a finished result still waits at the output
        if (rmw_go) begin
          state_nxt = ST_IDLE;
          if (last_r) begin
            out_valid_nxt = 1'b1;
            out_all_nxt   = hits_now;
            out_add_nxt   = (act_r == ACT_ADD);
            hits_nxt      = 1'b1;
          end else begin
            hits_nxt = hits_now;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      filter_bits_r <= FILTER_BITS_RESET;
      hits_r        <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        filter_bits_r <= cfg_wdata;
      end
    end
    out_all_r <= out_all_nxt;
    out_add_r <= out_add_nxt;
    if (accept) begin
      act_r  <= in_act;
      last_r <= in_last_word;
    end
    if (rd_en) begin
      bit_sel_r  <= mod_rem[ByteSelW-1:0];
      rmw_addr_r <= look_addr;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_all_present = out_all_r;
  assign out_was_add     = out_add_r;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the bloom filter membership block, with a shadow filter store.
module tb_top import bfm_pkg::*; ();

  localparam int STORE_BYTES   = (DEF_MAX_FILTER_BITS + BITS_PER_BYTE - 1) / BITS_PER_BYTE;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_KEY_WORDS = 8;
  localparam int RANDOM_BEATS  = 1400;
  localparam int KEEP_KEYS     = 48;

  typedef struct packed {
    logic all_present;
    logic was_add;
  } verdict_t;

  typedef logic [MAX_KEY_WORDS-1:0][HASH_W-1:0] key_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_W-1:0]       cfg_wdata;
  logic                   in_valid;
  logic                   in_ready;
  logic [1:0]             in_action;
  logic [HASH_W-1:0]      in_hash_word;
  logic                   in_last_word;
  logic [LOAD_ADDR_W-1:0] in_load_address;
  logic [7:0]             in_load_byte;
  logic                   out_valid;
  logic                   out_ready;
  logic                   out_all_present;
  logic                   out_was_add;

  // Shadow of the block's state
  logic [7:0]       shadow_filter [STORE_BYTES];
  logic             key_all_set;
  logic [CFG_W-1:0] filter_bits_cfg;
  verdict_t         expected_verdicts[$];

  key_t known_keys[$];
  int   known_lens[$];

  int beats_sent       = 0;
  int verdicts_checked = 0;
  int errors           = 0;
  int sink_hold_cycles = 0;
  bit no_gaps          = 1'b0;

  bloom_filter_membership dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_hash_word    (in_hash_word),
    .in_last_word    (in_last_word),
    .in_load_address (in_load_address),
    .in_load_byte    (in_load_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_all_present (out_all_present),
    .out_was_add     (out_was_add)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic void predict_membership(input act_t act, input logic [HASH_W-1:0] word,
                                             input logic last, input logic [LOAD_ADDR_W-1:0] addr,
                                             input logic [7:0] load_val);
    int unsigned size;
    int unsigned pos;
    int unsigned idx;
    verdict_t    v;
    if (act == ACT_LOAD) begin
      if (addr < STORE_BYTES) shadow_filter[addr] = load_val;
      return;
    end
    if (act == ACT_NONE) return;
    size = 32'(filter_bits_cfg);
    if (size == 0) size = 1;
    if (size > DEF_MAX_FILTER_BITS) size = DEF_MAX_FILTER_BITS;
    pos = word % size;
    idx = pos / BITS_PER_BYTE;
    if (idx >= STORE_BYTES) idx = 0;
    if (!shadow_filter[idx][pos % BITS_PER_BYTE]) begin
      key_all_set = 1'b0;
      if (act == ACT_ADD) shadow_filter[idx][pos % BITS_PER_BYTE] = 1'b1;
    end
    if (last) begin
      v.all_present = key_all_set;
      v.was_add     = (act == ACT_ADD);
      expected_verdicts.push_back(v);
      key_all_set = 1'b1;
    end
  endfunction

  // Valid stays high after a beat is taken; the next send either reuses it or drops it.
  task automatic send_beat(input act_t act, input logic [HASH_W-1:0] word, input logic last,
                           input logic [LOAD_ADDR_W-1:0] addr, input logic [7:0] load_val);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      if (in_valid) in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_action       <= act;
    in_hash_word    <= word;
    in_last_word    <= last;
    in_load_address <= addr;
    in_load_byte    <= load_val;
    in_valid        <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_membership(act, word, last, addr, load_val);
    if (act != ACT_NONE) beats_sent++;
  endtask

  task automatic send_key(input act_t act, input key_t k, input int len);
    for (int i = 0; i < len; i++)
      send_beat(act, k[i], i == len - 1, LOAD_ADDR_W'($urandom_range(0, 8191)),
                8'($urandom_range(0, 255)));
  endtask

  task automatic pause_until_drained();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (expected_verdicts.size() != 0);
  endtask

  // Loads and non-final words give no result, so allow the datapath to settle too.
  task automatic wait_idle();
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filter_bits(input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    filter_bits_cfg = value;
  endtask

  task automatic test_directed();
    send_beat(ACT_CHECK, 32'h0000_0000, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_ADD,   32'hFFFF_FFFF, 1'b1, 13'h1FFF, 8'hFF);
    send_beat(ACT_CHECK, 32'hFFFF_FFFF, 1'b1, 13'h1FFF, 8'hFF);
    // second word lands on the bit the first one just set
    send_beat(ACT_ADD,   32'h0001_0005, 1'b0, 13'd0, 8'h00);
    send_beat(ACT_ADD,   32'h0002_0005, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'h0003_0005, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_LOAD,  32'hFFFF_FFFF, 1'b1, 13'h1FFF, 8'h00);
    send_beat(ACT_CHECK, 32'hFFFF_FFFF, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_LOAD,  32'h0000_0000, 1'b0, 13'd0, 8'hFF);
    send_beat(ACT_CHECK, 32'h0000_0001, 1'b0, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'h0000_0007, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_NONE,  32'h0000_0000, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'h0000_0000, 1'b1, 13'd0, 8'h00);
    // mixed key: result reports the action of the final word
    send_beat(ACT_ADD,   32'd100, 1'b0, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'd100, 1'b1, 13'd0, 8'h00);
    // a load inside a key leaves the running hit flag alone
    send_beat(ACT_CHECK, 32'h0000_1234, 1'b0, 13'd0, 8'h00);
    send_beat(ACT_LOAD,  32'h0000_0000, 1'b1, 13'd5, 8'hAA);
    send_beat(ACT_CHECK, 32'h0000_0000, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'h0000_0029, 1'b1, 13'h1555, 8'h55);
  endtask

  task automatic test_size_extremes();
    key_t k;
    set_filter_bits('0);
    send_beat(ACT_CHECK, $urandom, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_LOAD,  $urandom, 1'b0, 13'd0, 8'hFE);
    send_beat(ACT_ADD,   $urandom, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_CHECK, $urandom, 1'b1, 13'd0, 8'h00);
    set_filter_bits(17'd1);
    send_beat(ACT_CHECK, $urandom, 1'b1, 13'd0, 8'h00);
    set_filter_bits(17'h1FFFF);
    send_beat(ACT_LOAD,  32'h0000_0000, 1'b0, 13'd0, 8'h00);
    send_beat(ACT_ADD,   32'h0003_0003, 1'b1, 13'd0, 8'h00);
    send_beat(ACT_CHECK, 32'h0000_0003, 1'b1, 13'd0, 8'h00);
    set_filter_bits(17'd65537);
    send_beat(ACT_CHECK, 32'h0005_0003, 1'b1, 13'd0, 8'h00);
    set_filter_bits(17'd8);
    send_beat(ACT_CHECK, 32'hFFFF_FFFB, 1'b1, 13'd0, 8'h00);
    set_filter_bits(17'd13);
    for (int i = 0; i < MAX_KEY_WORDS; i++) k[i] = $urandom;
    send_key(ACT_ADD, k, 3);
    send_key(ACT_CHECK, k, 3);
  endtask

  // Hold the result channel off long enough that the block backs up into its input.
  task automatic test_backpressure();
    key_t k;
    set_filter_bits(17'd512);
    no_gaps = 1'b1;
    sink_hold_cycles = 300;
    for (int i = 0; i < 24; i++) begin
      k[0] = $urandom;
      send_key($urandom_range(0, 1) ? ACT_ADD : ACT_CHECK, k, 1);
    end
    no_gaps = 1'b0;
  endtask

  task automatic test_sender_pause();
    key_t k;
    for (int i = 0; i < MAX_KEY_WORDS; i++) k[i] = $urandom;
    send_key(ACT_ADD, k, 4);
    send_key(ACT_CHECK, k, 4);
    pause_until_drained();
    send_key(ACT_CHECK, k, 4);
    send_key(ACT_ADD, k, 2);
  endtask

  task automatic test_random();
    logic [CFG_W-1:0] sizes [6];
    key_t        k;
    int          len;
    int          pick;
    int          target;
    int          sel;
    sizes[0] = FILTER_BITS_RESET;
    sizes[1] = CFG_W'($urandom_range(1, DEF_MAX_FILTER_BITS));
    sizes[2] = 17'd64;
    sizes[3] = 17'h1FFFF;
    sizes[4] = CFG_W'($urandom_range(9, 2000));
    sizes[5] = 17'd3;
    for (int p = 0; p < 6; p++) begin
      set_filter_bits(sizes[p]);
      known_keys.delete();
      known_lens.delete();
      target = beats_sent + RANDOM_BEATS / 6;
      while (beats_sent < target) begin
        if ($urandom_range(0, 39) == 0) no_gaps = ($urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        len  = ($urandom_range(0, 3) == 0) ? $urandom_range(5, MAX_KEY_WORDS)
                                           : $urandom_range(1, 4);
        for (int i = 0; i < MAX_KEY_WORDS; i++) k[i] = $urandom;
        if (pick < 35 || known_keys.size() == 0) begin
          send_key(ACT_ADD, k, len);
          known_keys.push_back(k);
          known_lens.push_back(len);
          if (known_keys.size() > KEEP_KEYS) begin
            void'(known_keys.pop_front());
            void'(known_lens.pop_front());
          end
        end else if (pick < 70) begin
          sel = $urandom_range(0, known_keys.size() - 1);
          send_key(pick < 60 ? ACT_CHECK : ACT_ADD, known_keys[sel], known_lens[sel]);
        end else if (pick < 80) begin
          send_key(ACT_CHECK, k, len);
        end else if (pick < 88) begin
          for (int i = 0; i < len; i++)
            send_beat($urandom_range(0, 1) ? ACT_ADD : ACT_CHECK, k[i], i == len - 1,
                      LOAD_ADDR_W'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        end else if (pick < 94) begin
          send_beat(ACT_LOAD, $urandom, 1'($urandom_range(0, 1)),
                    LOAD_ADDR_W'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        end else begin
          send_beat(ACT_NONE, $urandom, 1'($urandom_range(0, 1)),
                    LOAD_ADDR_W'($urandom_range(0, 8191)), 8'($urandom_range(0, 255)));
        end
      end
      no_gaps = 1'b0;
    end
  endtask

  // Result channel: draw a stall per beat, or take a requested long hold-off.
  initial begin
    int unsigned stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (sink_hold_cycles != 0) begin
        out_ready <= 1'b0;
        repeat (sink_hold_cycles) @(posedge clk);
        sink_hold_cycles = 0;
      end else begin
        stall = no_gaps ? 0 : $urandom_range(0, 7);
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_verdicts.size() == 0) begin
        $error("unexpected result beat: all_present=%0b was_add=%0b",
               out_all_present, out_was_add);
        errors++;
      end else begin
        want = expected_verdicts.pop_front();
        verdicts_checked++;
        if (out_all_present !== want.all_present) begin
          $error("all_present: expected %0b, actual %0b", want.all_present, out_all_present);
          errors++;
        end
        if (out_was_add !== want.was_add) begin
          $error("was_add: expected %0b, actual %0b", want.was_add, out_was_add);
          errors++;
        end
      end
    end
  end

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= FILTER_BITS_RESET;
    in_valid        <= 1'b0;
    in_action       <= ACT_CHECK;
    in_hash_word    <= '0;
    in_last_word    <= 1'b0;
    in_load_address <= '0;
    in_load_byte    <= '0;
    filter_bits_cfg = FILTER_BITS_RESET;
    key_all_set     = 1'b1;
    foreach (shadow_filter[i]) shadow_filter[i] = 8'h00;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_size_extremes();
    test_backpressure();
    test_sender_pause();
    test_random();
    wait_idle();

    $display("Sent %0d beats and checked %0d key results across directed, filter size,",
             beats_sent, verdicts_checked);
    $display("backpressure and randomized phases.");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
